// ===== rtl/core/tts_pkg.sv =====
// Shared types and codes for the timed task scheduler.
package tts_pkg;

   localparam logic [2:0] OP_STEP   = 3'd0;
   localparam logic [2:0] OP_IMMED  = 3'd1;
   localparam logic [2:0] OP_IRQ    = 3'd2;
   localparam logic [2:0] OP_UNTIL  = 3'd3;
   localparam logic [2:0] OP_FOR    = 3'd4;
   localparam logic [2:0] OP_REMOVE = 3'd5;
   // Unassigned opcodes: no effect on any store.
   localparam logic [2:0] OP_RSVD6  = 3'd6;
   localparam logic [2:0] OP_RSVD7  = 3'd7;

   localparam logic [2:0] SRC_IRQ      = 3'd0;
   localparam logic [2:0] SRC_DEFERRED = 3'd1;
   localparam logic [2:0] SRC_IMMED    = 3'd2;
   localparam logic [2:0] SRC_IDLE     = 3'd3;
   localparam logic [2:0] SRC_NONE     = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   localparam logic CSR_IDLE_ID     = 1'b0;
   localparam logic CSR_IDLE_ENABLE = 1'b1;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  task_id;
      logic [31:0] time_value;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic [7:0] chosen_task;
      logic       chosen_valid;
      logic [2:0] chosen_source;
      logic [1:0] status;
      logic [7:0] deferred_head_task;
      logic       next_deferred_valid;
   } rsp_type;

   // Deferred entry: due time and task id.
   typedef struct packed {
      logic [31:0] due;
      logic [7:0]  task_id;
   } dentry_type;

endpackage

// ===== rtl/core/tts_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module tts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/core/tts_fifo.sv =====
// Task-id FIFO built on the generic RAM, with a registered head word.
module tts_fifo #(
   parameter int DEPTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic [7:0] push_data,
   input  logic       pop,
   output logic       empty,
   output logic       full,
   output logic [7:0] head_data
);
   localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2);
   localparam int CW = $clog2(DEPTH + 1);

   logic [AW-1:0] rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   function automatic logic [AW-1:0] incr(input logic [AW-1:0] p);
      logic [AW-1:0] r;
      if (p == AW'(DEPTH - 1)) r = '0;
      else r = p + AW'(1);
      return r;
   endfunction

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = incr(wr_ptr_ff);
         count_in  = count_in + CW'(1);
      end
      if (pop) begin
         rd_ptr_in = incr(rd_ptr_ff);
         count_in  = count_in - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CW'(DEPTH));

   // Read address follows the next pointer so the head word is registered as the pointer moves.
   tts_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wr_ptr_ff),
      .wr_data (push_data),
      .rd_addr (rd_ptr_in),
      .rd_data (head_data)
   );
endmodule

// ===== rtl/core/timed_task_scheduler_unit.sv =====
// Timed task scheduler top level: sequencer, FIFOs and sorted deferred list.
// Sequence: each request passes S_HEAD_RD, S_DECIDE, S_HEAD_FIN and S_HEAD_WAIT to S_RESP;
// a defer or remove may walk the deferred list (fill at most DEFERRED_DEPTH) in between.
// Throughput: one request at a time, the next taken the cycle after the response
// beat; the deferred walk, one read and at most one write per entry, dominates.
// Reset: synchronous, active high; counts and pointers clear, RAMs do not.
module timed_task_scheduler_unit #(
   parameter int IRQ_DEPTH      = 8,
   parameter int IMMED_DEPTH    = 16,
   parameter int DEFERRED_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tts_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [0:0]       csr_index,
   input  logic [7:0]       csr_wdata
);
   import tts_pkg::*;

   localparam int DW = $clog2(DEFERRED_DEPTH > 1 ? DEFERRED_DEPTH : 2);
   localparam int DC = $clog2(DEFERRED_DEPTH + 1);

   // States of the sequencer. The deferred list lives in a RAM with index
   // count-1 as the head, exactly as a sorted array with the due-first
   // entry on top. Insert walks downward from the top shifting entries up;
   // remove walks upward compacting entries that do not match.
   typedef enum logic [3:0] {
      S_IDLE, S_HEAD_RD, S_DECIDE, S_INS_RD, S_INS_CMP,
      S_REM_RD, S_REM_CMP, S_HEAD_FIN, S_HEAD_WAIT, S_RESP
   } state_type;

   state_type     state_ff;
   req_type       req_ff;
   rsp_type       rsp_ff;
   logic [7:0]    idle_id_ff;
   logic          idle_en_ff;
   logic [DC-1:0] dcount_ff;
   logic [DC-1:0] idx_ff;      // walk position (read pointer)
   logic [DC-1:0] widx_ff;     // compaction write pointer
   logic          found_ff;
   logic [31:0]   due_ff;

   // Deferred RAM ports.
   logic          dram_we;
   logic [DW-1:0] dram_waddr, dram_raddr;
   dentry_type    dram_wdata, dram_rdata;

   // FIFO controls.
   logic irq_push, irq_pop, irq_empty, irq_full;
   logic imm_push, imm_pop, imm_empty, imm_full;
   logic [7:0] irq_head, imm_head;

   // Shared comparator: a precedes b when a - b is negative.
   logic [31:0] cmp_a, cmp_b, cmp_diff;
   logic        cmp_prec;
   assign cmp_diff = cmp_a - cmp_b;
   assign cmp_prec = cmp_diff[31];

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data  = rsp_ff;

   logic [DC-1:0] top_idx;
   assign top_idx = dcount_ff - DC'(1);

   always_comb begin
      dram_raddr = idx_ff[DW-1:0];
      cmp_a      = due_ff;
      cmp_b      = dram_rdata.due;
      if (state_ff == S_DECIDE) begin
         cmp_a = req_ff.now;
      end
      // The count is final here, so the head of the list is read for the response.
      if (state_ff == S_HEAD_FIN) begin
         dram_raddr = top_idx[DW-1:0];
      end
   end

   assign irq_push = (state_ff == S_DECIDE) && (req_ff.opcode == OP_IRQ) && !irq_full;
   assign imm_push = (state_ff == S_DECIDE) && (req_ff.opcode == OP_IMMED) && !imm_full;
   assign irq_pop  = (state_ff == S_DECIDE) && (req_ff.opcode == OP_STEP) && !irq_empty;
   assign imm_pop  = (state_ff == S_DECIDE) && (req_ff.opcode == OP_STEP) && irq_empty
                     && !((dcount_ff != '0) && !cmp_prec) && !imm_empty;

   always_comb begin
      dram_we    = 1'b0;
      dram_waddr = idx_ff[DW-1:0];
      dram_wdata = dram_rdata;
      case (state_ff)
         S_INS_CMP: begin
            dram_we = 1'b1;
            if ((widx_ff != '0) && !cmp_prec) begin
               dram_waddr = widx_ff[DW-1:0];
               dram_wdata = dram_rdata;
            end else begin
               dram_waddr = widx_ff[DW-1:0];
               dram_wdata = '{due: due_ff, task_id: req_ff.task_id};
            end
         end
         S_REM_CMP: begin
            dram_we    = (dram_rdata.task_id != req_ff.task_id);
            dram_waddr = widx_ff[DW-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         idle_id_ff <= '0;
         idle_en_ff <= 1'b0;
         dcount_ff  <= '0;
         idx_ff     <= '0;
         widx_ff    <= '0;
         found_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IDLE_ID:     idle_id_ff <= csr_wdata;
               CSR_IDLE_ENABLE: idle_en_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_data;
                  idx_ff   <= dcount_ff - DC'(1);
                  state_ff <= S_HEAD_RD;
               end
            end
            S_HEAD_RD: begin
               // RAM presents the head entry next cycle.
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               rsp_ff.chosen_task   <= '0;
               rsp_ff.chosen_valid  <= 1'b0;
               rsp_ff.chosen_source <= SRC_NONE;
               rsp_ff.status        <= ST_OK;
               state_ff             <= S_HEAD_FIN;
               case (req_ff.opcode)
                  OP_STEP: begin
                     rsp_ff.chosen_valid <= 1'b1;
                     if (!irq_empty) begin
                        rsp_ff.chosen_task   <= irq_head;
                        rsp_ff.chosen_source <= SRC_IRQ;
                     end else if ((dcount_ff != '0) && !cmp_prec) begin
                        rsp_ff.chosen_task   <= dram_rdata.task_id;
                        rsp_ff.chosen_source <= SRC_DEFERRED;
                        dcount_ff            <= dcount_ff - DC'(1);
                     end else if (!imm_empty) begin
                        rsp_ff.chosen_task   <= imm_head;
                        rsp_ff.chosen_source <= SRC_IMMED;
                     end else if (idle_en_ff) begin
                        rsp_ff.chosen_task   <= idle_id_ff;
                        rsp_ff.chosen_source <= SRC_IDLE;
                     end else begin
                        rsp_ff.chosen_valid  <= 1'b0;
                     end
                  end
                  OP_IMMED: if (imm_full) rsp_ff.status <= ST_FULL;
                  OP_IRQ:   if (irq_full) rsp_ff.status <= ST_FULL;
                  OP_UNTIL, OP_FOR: begin
                     due_ff <= (req_ff.opcode == OP_FOR) ?
                               req_ff.now + req_ff.time_value : req_ff.time_value;
                     if (dcount_ff == DC'(DEFERRED_DEPTH)) begin
                        rsp_ff.status <= ST_FULL;
                     end else begin
                        // widx is the slot being opened; idx reads the one below.
                        widx_ff  <= dcount_ff;
                        idx_ff   <= dcount_ff - DC'(1);
                        state_ff <= (dcount_ff == '0) ? S_INS_CMP : S_INS_RD;
                     end
                  end
                  OP_REMOVE: begin
                     found_ff <= 1'b0;
                     widx_ff  <= '0;
                     idx_ff   <= '0;
                     state_ff <= (dcount_ff == '0) ? S_HEAD_FIN : S_REM_RD;
                     if (dcount_ff == '0) rsp_ff.status <= ST_NOT_FOUND;
                  end
                  default: ;
               endcase
            end
            S_INS_RD: state_ff <= S_INS_CMP;
            S_INS_CMP: begin
               // Entry below moves up when the new time does not precede it.
               if ((widx_ff != '0) && !cmp_prec) begin
                  widx_ff  <= widx_ff - DC'(1);
                  idx_ff   <= widx_ff - DC'(2);
                  state_ff <= (widx_ff == DC'(1)) ? S_INS_CMP : S_INS_RD;
               end else begin
                  dcount_ff <= dcount_ff + DC'(1);
                  state_ff  <= S_HEAD_FIN;
               end
            end
            S_REM_RD: state_ff <= S_REM_CMP;
            S_REM_CMP: begin
               if (dram_rdata.task_id == req_ff.task_id) found_ff <= 1'b1;
               else widx_ff <= widx_ff + DC'(1);
               if (idx_ff == top_idx) begin
                  dcount_ff <= (dram_rdata.task_id == req_ff.task_id) ?
                               widx_ff : widx_ff + DC'(1);
                  if (!found_ff && dram_rdata.task_id != req_ff.task_id)
                     rsp_ff.status <= ST_NOT_FOUND;
                  state_ff <= S_HEAD_FIN;
               end else begin
                  idx_ff   <= idx_ff + DC'(1);
                  state_ff <= S_REM_RD;
               end
            end
            S_HEAD_FIN: begin
               state_ff <= S_HEAD_WAIT;
            end
            S_HEAD_WAIT: begin
               // The new head arrives from the RAM; capture it for the response.
               rsp_ff.next_deferred_valid <= (dcount_ff != '0);
               rsp_ff.deferred_head_task  <= (dcount_ff != '0) ? dram_rdata.task_id : '0;
               state_ff                   <= S_RESP;
            end
            S_RESP: begin
               if (rsp_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   tts_ram #(.WIDTH($bits(dentry_type)), .DEPTH(DEFERRED_DEPTH)) u_dram (
      .clock   (clock),
      .wr_en   (dram_we),
      .wr_addr (dram_waddr),
      .wr_data (dram_wdata),
      .rd_addr (dram_raddr),
      .rd_data (dram_rdata)
   );

   tts_fifo #(.DEPTH(IRQ_DEPTH)) u_irq (
      .clock(clock), .reset(reset), .push(irq_push), .push_data(req_ff.task_id),
      .pop(irq_pop), .empty(irq_empty), .full(irq_full), .head_data(irq_head)
   );

   tts_fifo #(.DEPTH(IMMED_DEPTH)) u_imm (
      .clock(clock), .reset(reset), .push(imm_push), .push_data(req_ff.task_id),
      .pop(imm_pop), .empty(imm_empty), .full(imm_full), .head_data(imm_head)
   );
endmodule

// ===== rtl/core/tts_checker.sv =====
// Port-level checks for the timed task scheduler, bound to the top level.
module tts_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input tts_pkg::rsp_type rsp_data
);
   import tts_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a response waits");

   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.chosen_valid == (rsp_data.chosen_source != SRC_NONE)))
      else $error("chosen_valid disagrees with source");

   a_step_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.chosen_valid |-> rsp_data.status == ST_OK)
      else $error("step reported an error status");
endmodule

bind timed_task_scheduler_unit tts_checker u_tts_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);

// ===== dv/tts_checker.sv =====
// Checker for the timed task scheduler: predicts each response beat and compares it.
module tts_scoreboard
   import tts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   input  logic    csr_valid,
   input  logic    csr_ready,
   input  logic    csr_index,
   input  logic [7:0] csr_wdata,
   output int      fail_count,
   output int      pending_count
);

   localparam int IRQ_N = 8;
   localparam int IMM_N = 16;
   localparam int DEF_N = 16;

   logic [7:0]  idle_id;
   logic        idle_en;
   logic [7:0]  irq_q[$];
   logic [7:0]  imm_q[$];
   // Index 0 is the entry due first.
   logic [31:0] due_list[$];
   logic [7:0]  due_task[$];
   rsp_type     expected_rsps[$];

   function automatic logic is_earlier(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
   endfunction

   // Ties go behind existing entries so equal due times leave in insertion order.
   function automatic logic [1:0] insert_due(logic [7:0] id, logic [31:0] at);
      int pos;
      if (due_list.size() >= DEF_N) return ST_FULL;
      pos = due_list.size();
      for (int i = 0; i < due_list.size(); i++)
         if (is_earlier(at, due_list[i])) begin
            pos = i;
            break;
         end
      due_list.insert(pos, at);
      due_task.insert(pos, id);
      return ST_OK;
   endfunction

   function automatic rsp_type schedule(req_type r);
      rsp_type o;
      logic found;
      o = '0;
      o.chosen_source = SRC_NONE;
      o.status = ST_OK;
      case (r.opcode)
         OP_STEP: begin
            if (irq_q.size() > 0) begin
               o.chosen_task = irq_q.pop_front();
               o.chosen_valid = 1'b1;
               o.chosen_source = SRC_IRQ;
            end else if (due_list.size() > 0 && !is_earlier(r.now, due_list[0])) begin
               o.chosen_task = due_task.pop_front();
               void'(due_list.pop_front());
               o.chosen_valid = 1'b1;
               o.chosen_source = SRC_DEFERRED;
            end else if (imm_q.size() > 0) begin
               o.chosen_task = imm_q.pop_front();
               o.chosen_valid = 1'b1;
               o.chosen_source = SRC_IMMED;
            end else if (idle_en) begin
               o.chosen_task = idle_id;
               o.chosen_valid = 1'b1;
               o.chosen_source = SRC_IDLE;
            end
         end
         OP_IMMED: begin
            if (imm_q.size() >= IMM_N) o.status = ST_FULL;
            else imm_q.push_back(r.task_id);
         end
         OP_IRQ: begin
            if (irq_q.size() >= IRQ_N) o.status = ST_FULL;
            else irq_q.push_back(r.task_id);
         end
         OP_UNTIL: o.status = insert_due(r.task_id, r.time_value);
         OP_FOR:   o.status = insert_due(r.task_id, r.now + r.time_value);
         OP_REMOVE: begin
            found = 1'b0;
            for (int i = due_task.size() - 1; i >= 0; i--)
               if (due_task[i] == r.task_id) begin
                  found = 1'b1;
                  due_task.delete(i);
                  due_list.delete(i);
               end
            if (!found) o.status = ST_NOT_FOUND;
         end
         default: ;
      endcase
      if (due_task.size() > 0) begin
         o.deferred_head_task = due_task[0];
         o.next_deferred_valid = 1'b1;
      end
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         idle_id = 8'd0;
         idle_en = 1'b0;
         irq_q.delete();
         imm_q.delete();
         due_list.delete();
         due_task.delete();
         expected_rsps.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_IDLE_ID) idle_id = csr_wdata;
            else idle_en = csr_wdata[0];
         end
         if (req_valid && req_ready) expected_rsps.push_back(schedule(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("response beat with no request outstanding");
               fail_count <= fail_count + 1;
            end else begin
               e = expected_rsps.pop_front();
               if (e !== rsp_data) begin
                  fail_count <= fail_count + 1;
                  if (e.chosen_task !== rsp_data.chosen_task)
                     $error("chosen_task exp %0d got %0d", e.chosen_task,
                            rsp_data.chosen_task);
                  if (e.chosen_valid !== rsp_data.chosen_valid)
                     $error("chosen_valid exp %0d got %0d", e.chosen_valid,
                            rsp_data.chosen_valid);
                  if (e.chosen_source !== rsp_data.chosen_source)
                     $error("chosen_source exp %0d got %0d", e.chosen_source,
                            rsp_data.chosen_source);
                  if (e.status !== rsp_data.status)
                     $error("status exp %0d got %0d", e.status, rsp_data.status);
                  if (e.deferred_head_task !== rsp_data.deferred_head_task)
                     $error("deferred_head_task exp %0d got %0d",
                            e.deferred_head_task, rsp_data.deferred_head_task);
                  if (e.next_deferred_valid !== rsp_data.next_deferred_valid)
                     $error("next_deferred_valid exp %0d got %0d",
                            e.next_deferred_valid, rsp_data.next_deferred_valid);
               end
            end
         end
         pending_count <= expected_rsps.size();
      end
   end

endmodule

// ===== dv/tb_timed_task_scheduler_unit.sv =====
// Testbench top for the timed task scheduler: stimulus, stalls and the verdict.
module tb_timed_task_scheduler_unit;
   import tts_pkg::*;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = CSR_IDLE_ID;
   logic [7:0] csr_wdata = 8'd0;
   int         fail_count;
   int         pending_count;

   // The receiver stalls at random unless the long hold-off below is active.
   logic       hold_off = 1'b0;
   int         stall_pct = 30;

   // A rolling time base; now mostly advances but sometimes jumps or wraps.
   logic [31:0] clock_now = 32'hFFFF_FF00;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   timed_task_scheduler_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   tts_scoreboard i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // Receiver: its own stall pattern, with stretches of no stalls when stall_pct is 0.
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
   end

   // Sends one request beat, holding valid and payload until it is accepted.
   task automatic send_req(logic [2:0] op, logic [7:0] id, logic [31:0] tv,
                           logic [31:0] tnow);
      req_data  <= '{opcode: op, task_id: id, time_value: tv, now: tnow};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // Lowers valid after a burst and waits a random gap.
   task automatic idle_gap(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [7:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Waits until every response has come back, then past the longest walk,
   // so a register write never lands while the block is busy.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (40) @(posedge clock);
   endtask

   // Random request weighted toward deep behavior: mostly steps and defers
   // with a small id pool so removes hit, and times near now so entries fall due.
   task automatic random_req();
      int          pick;
      logic [2:0]  op;
      logic [7:0]  id;
      logic [31:0] tv;
      pick = $urandom_range(99);
      if (pick < 30) op = OP_STEP;
      else if (pick < 42) op = OP_IMMED;
      else if (pick < 50) op = OP_IRQ;
      else if (pick < 64) op = OP_UNTIL;
      else if (pick < 80) op = OP_FOR;
      else if (pick < 94) op = OP_REMOVE;
      else op = 3'($urandom_range(7));
      id = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
      case ($urandom_range(3))
         0: tv = $urandom;
         1: tv = clock_now + $urandom_range(64) - 32;
         default: tv = $urandom_range(48);
      endcase
      if (op == OP_UNTIL && $urandom_range(1)) tv = clock_now + $urandom_range(40);
      if ($urandom_range(49) == 0) clock_now = $urandom;
      else clock_now = clock_now + $urandom_range(6);
      send_req(op, id, tv, clock_now);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty step, a full IRQ FIFO, wrap-around times, ties and removal.
      send_req(OP_STEP, 8'd0, 32'd0, 32'd0);
      send_req(OP_RSVD6, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_req(OP_RSVD7, 8'h00, 32'd0, 32'd0);
      for (int i = 0; i < 9; i++) send_req(OP_IRQ, 8'(8'hF0 + i), 32'd0, 32'd0);
      send_req(OP_UNTIL, 8'hAA, 32'h0000_0010, 32'hFFFF_FFF0);
      send_req(OP_FOR, 8'h55, 32'h0000_0020, 32'hFFFF_FFF0);
      send_req(OP_UNTIL, 8'h11, 32'h0000_0010, 32'hFFFF_FFF0);
      send_req(OP_REMOVE, 8'h55, 32'd0, 32'd0);
      send_req(OP_REMOVE, 8'h55, 32'd0, 32'd0);
      send_req(OP_IMMED, 8'hFF, 32'd0, 32'd0);
      for (int i = 0; i < 9; i++) send_req(OP_STEP, 8'd0, 32'd0, 32'h0000_0000);
      for (int i = 0; i < 4; i++) send_req(OP_STEP, 8'd0, 32'd0, 32'h0000_0010);
      drain();

      // Fill the immediate FIFO and the deferred list past their depths.
      write_csr(CSR_IDLE_ID, 8'hFF);
      write_csr(CSR_IDLE_ENABLE, 8'd1);
      for (int i = 0; i < 17; i++) send_req(OP_IMMED, 8'(i), 32'd0, 32'd0);
      for (int i = 0; i < 17; i++) send_req(OP_UNTIL, 8'(i), 32'($urandom_range(3)), 32'd0);
      for (int i = 0; i < 36; i++) send_req(OP_STEP, 8'd0, 32'd0, 32'd2);
      drain();

      // Random phases, each with its own idle setting and stall level.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin write_csr(CSR_IDLE_ID, 8'h00); write_csr(CSR_IDLE_ENABLE, 8'd0); end
            1: write_csr(CSR_IDLE_ID, 8'h5A);
            2: write_csr(CSR_IDLE_ENABLE, 8'd1);
            default: write_csr(CSR_IDLE_ID, 8'($urandom));
         endcase
         stall_pct = (phase == 3) ? 0 : $urandom_range(60);
         if (phase == 1) begin
            // Hold the receiver off long enough for the block to back up.
            fork
               begin
                  hold_off = 1'b1;
                  repeat (400) @(posedge clock);
                  hold_off = 1'b0;
               end
            join_none
         end
         for (int n = 0; n < 270; ) begin
            int burst;
            burst = $urandom_range(12, 1);
            for (int b = 0; b < burst; b++) begin
               random_req();
               n++;
            end
            if (phase != 3) idle_gap($urandom_range(6));
         end
         drain();
      end

      if (fail_count == 0) $display("** timed_task_scheduler_unit: PASSED **");
      else $display("** timed_task_scheduler_unit: FAILED **");
      $finish;
   end

   initial begin
      #2000000;
      $display("** timed_task_scheduler_unit: FAILED **");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/tts_pkg.sv
rtl/core/tts_ram.sv
rtl/core/tts_fifo.sv
rtl/core/timed_task_scheduler_unit.sv
rtl/core/tts_checker.sv
dv/tts_checker.sv
dv/tb_timed_task_scheduler_unit.sv
